>>> rtl/bthc_pkg.sv
// Package: shared types, codes and constants of the button tap/hold classifier.
package bthc_pkg;

    // Number of tracked buttons; fixes the width of every mask field.
    localparam int NUM_BUTTONS = 14;

    // Default width, in bits, of stored press times, which count ticks.
    localparam int TIME_BITS_DEF = 32;

    // Width of the tick stamp and of the hold threshold register.
    localparam int TICK_W = 32;

    // Hold threshold after reset.
    localparam logic [TICK_W-1:0] HOLD_THR_RESET = TICK_W'(500);

    // Item actions.
    localparam logic ACT_UPDATE     = 1'b0;
    localparam logic ACT_IGNORE_ALL = 1'b1;

    // Release classes.
    typedef logic [1:0] t_cls;
    localparam t_cls CLS_NONE = 2'd0;
    localparam t_cls CLS_TAP  = 2'd1;
    localparam t_cls CLS_HOLD = 2'd2;

    typedef logic [NUM_BUTTONS-1:0] t_mask;

    // Input transaction.
    typedef struct packed {
        logic              action;
        logic [TICK_W-1:0] now_tick;
        logic              connected;
        t_mask             held_mask;
    } t_in_item;

    // Result transaction.
    typedef struct packed {
        t_mask down_mask;
        t_mask raw_down_mask;
        t_mask ignored_mask;
        t_mask tap_mask;
        t_mask hold_mask;
        logic  link_flag;
    } t_out_item;

    // Per-item control handed to every button lane.
    typedef struct packed {
        logic adv;      // apply the item held in the input register
        logic ign_all;  // ignore-all item
        logic conn;     // connected flag of the item, used by update items
    } t_lane_ctl;

    // Per-button status returned by a lane.
    typedef struct packed {
        logic down;
        logic ignored;
        t_cls cls;
    } t_lane_st;

endpackage

>>> rtl/bthc_lane.sv
// Per-button lane: press time, down and ignore flags, and release classification.
module bthc_lane import bthc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_lane_ctl            i_ctl,
    input  logic                 i_held,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [TICK_W-1:0]    i_thr,
    output t_lane_st             o_st
);

    localparam int CMP_W = (TIME_BITS > TICK_W) ? TIME_BITS : TICK_W;

    logic [TIME_BITS-1:0] r_press;
    logic [TIME_BITS-1:0] n_press;
    logic                 r_down;
    logic                 n_down;
    logic                 r_ign;
    logic                 n_ign;
    t_cls                 r_cls;
    t_cls                 n_cls;
    logic [TIME_BITS-1:0] elapsed;
    logic                 is_hold;

    // Modular tick difference, compared at the wider of the two widths.
    assign elapsed = i_now - r_press;
    assign is_hold = CMP_W'(elapsed) >= CMP_W'(i_thr);

    always_comb begin
        n_press = r_press;
        n_down  = r_down;
        n_ign   = r_ign;
        n_cls   = r_cls;
        if (i_ctl.adv) begin
            priority if (i_ctl.ign_all) begin
                n_ign = r_ign | r_down;
            end else if (!i_ctl.conn) begin
                n_cls = CLS_NONE;
            end else if (!r_down) begin
                n_cls = CLS_NONE;
                if (i_held) begin
                    n_down  = 1'b1;
                    n_press = i_now;
                end
            end else if (!i_held) begin
                n_ign  = 1'b0;
                n_down = 1'b0;
                n_cls  = is_hold ? CLS_HOLD : CLS_TAP;
            end else begin
                // still held: keep everything
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down <= 1'b0;
            r_ign  <= 1'b0;
            r_cls  <= CLS_NONE;
        end else begin
            r_down <= n_down;
            r_ign  <= n_ign;
            r_cls  <= n_cls;
        end
    end

    // Press time is only read while the button is down, so it needs no reset.
    always_ff @(posedge i_clk) begin
        r_press <= n_press;
    end

    assign o_st.down    = r_down;
    assign o_st.ignored = r_ign;
    assign o_st.cls     = r_cls;

endmodule

>>> rtl/button_tap_hold_classifier_unit.sv
// Top level: button tap/hold release classifier with valid/stall channels.
//
// Tracks NUM_BUTTONS buttons and classifies each release as tap or hold
// against the hold threshold register. Every input transaction yields
// exactly one result transaction. An accepted transaction is captured in an
// input register; on the next cycle in which the result side can take it, the
// per-button lanes apply it (one subtract and compare per lane) and the new
// state becomes the result. With no stalls a transaction passes from the input
// register into the lane state registers, which form the result, and one
// transaction is taken every cycle. The input stalls only while
// both the input register and the result are full and the result is stalled.
// The result fields are read straight from the lane state registers, which
// stay frozen while the result is stalled. The threshold is written through
// i_cfg_we / i_cfg_wdata and takes effect for transactions applied afterwards;
// write it only while no transaction is in flight. TIME_BITS sets the width of
// stored press times; elapsed time is taken modulo 2^TIME_BITS.
module button_tap_hold_classifier_unit import bthc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out
);

    // Hold threshold register.
    logic [TICK_W-1:0] r_hold_thr;

    // Input register.
    logic     r_in_valid;
    logic     n_in_valid;
    t_in_item r_in;

    // Result valid and connection flag; the rest of the result is lane state.
    logic r_out_valid;
    logic n_out_valid;
    logic r_link_up;
    logic n_link_up;

    logic      out_free;   // result slot empty or being taken this cycle
    logic      apply;      // apply the held transaction to the state
    t_lane_ctl lane_ctl;
    t_lane_st  lane_st [NUM_BUTTONS];
    logic [TIME_BITS-1:0] now_t;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign apply      = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Keep only the low TIME_BITS bits of the tick, or zero-extend it.
    assign now_t = TIME_BITS'(r_in.now_tick);

    assign lane_ctl.adv     = apply;
    assign lane_ctl.ign_all = (r_in.action == ACT_IGNORE_ALL);
    assign lane_ctl.conn    = r_in.connected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_thr <= HOLD_THR_RESET;
        end else if (i_cfg_we) begin
            r_hold_thr <= i_cfg_wdata;
        end
    end

    // Take a new transaction whenever the input register is empty or draining.
    always_comb begin
        n_in_valid = r_in_valid;
        if (!r_in_valid || out_free) begin
            n_in_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_in_valid || out_free) begin
            r_in <= i_in;
        end
    end

    // Result becomes valid when a transaction is applied, drops when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = apply;
        end
    end

    // Link flag follows update transactions only; ignore-all leaves it alone.
    always_comb begin
        n_link_up = r_link_up;
        if (apply && (r_in.action == ACT_UPDATE)) begin
            n_link_up = r_in.connected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_link_up   <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_link_up   <= n_link_up;
        end
    end

    // One lane per button.
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bthc_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_held  (r_in.held_mask[g]),
            .i_now   (now_t),
            .i_thr   (r_hold_thr),
            .o_st    (lane_st[g])
        );
    end

    // Gather lane state into the result masks.
    always_comb begin
        o_out = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            o_out.down_mask[b]     = r_link_up && lane_st[b].down && !lane_st[b].ignored;
            o_out.raw_down_mask[b] = lane_st[b].down;
            o_out.ignored_mask[b]  = lane_st[b].ignored;
            o_out.tap_mask[b]      = (lane_st[b].cls == CLS_TAP);
            o_out.hold_mask[b]     = (lane_st[b].cls == CLS_HOLD);
        end
        o_out.link_flag = r_link_up;
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/bthc_checker.sv
// Checker: port-level assertions for the tap/hold classifier, bound to the top level.
module bthc_checker import bthc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    // Hold a stalled result unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    // No released button is classified both tap and hold.
    a_cls_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.tap_mask & o_out.hold_mask) == '0))
        else $error("button classified both tap and hold");

    // Drop ignore marks on release: only down buttons may be ignored.
    a_ign_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.ignored_mask & ~o_out.raw_down_mask) == '0))
        else $error("ignore mark on a button that is up");

    // Filtered down mask lies within the raw one.
    a_down_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.down_mask & ~o_out.raw_down_mask) == '0))
        else $error("down mask outside raw down mask");

    // While disconnected, report no down buttons and no release classes.
    a_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.link_flag) |->
            ((o_out.down_mask == '0) && (o_out.tap_mask == '0)
             && (o_out.hold_mask == '0)))
        else $error("activity reported while disconnected");

endmodule

bind button_tap_hold_classifier_unit bthc_checker u_bthc_checker (.*);
